FILE: sv/chc_pkg.sv
// shared types, constants and lookup tables for the cartridge header checker
package chc_pkg;

  localparam int LOGO_BYTES = 48;

  localparam logic [6:0] WINDOW_LEN = 7'd76;
  localparam logic [6:0] SUM_FIRST  = 7'h30;
  localparam logic [6:0] SUM_END    = 7'h49;
  localparam logic [6:0] OFS_TYPE   = 7'h43;
  localparam logic [6:0] OFS_ROM    = 7'h44;
  localparam logic [6:0] OFS_RAM    = 7'h45;
  localparam logic [6:0] OFS_STORED = 7'h49;

  localparam logic [7:0] MAX_TYPE = 8'd31;
  localparam logic [7:0] MAX_ROM  = 8'd6;
  localparam logic [7:0] MAX_RAM  = 8'd4;

  localparam logic [7:0] LOGO_TABLE [LOGO_BYTES] = '{
    8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b, 8'h03, 8'h73, 8'h00, 8'h83,
    8'h00, 8'h0c, 8'h00, 8'h0d, 8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
    8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99, 8'hbb, 8'hbb, 8'h67, 8'h63,
    8'h6e, 8'h0e, 8'hec, 8'hcc, 8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e
  };

  // 4-bit two's complement, 4'hf is unsupported
  localparam logic [3:0] MAPPER_TABLE [32] = '{
    4'h0, 4'h1, 4'h1, 4'h1, 4'hf, 4'h2, 4'h2, 4'hf,
    4'h0, 4'h0, 4'hf, 4'h0, 4'h0, 4'h0, 4'hf, 4'h3,
    4'h3, 4'h3, 4'h3, 4'h3, 4'hf, 4'hf, 4'hf, 4'hf,
    4'hf, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h0
  };

  // one classified header byte, front to back
  typedef struct packed {
    logic [7:0] data;
    logic       logo_bad;
    logic       sum_en;
    logic       type_wr;
    logic       rom_wr;
    logic       ram_wr;
    logic       stored_wr;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [17:0]       ram_bytes;
    logic [4:0]        ram_bank_cnt;
    logic [7:0]        rom_bank_cnt;
    logic signed [3:0] mapper;
    logic              ok;
  } result_t;

  function automatic logic [4:0] ram_bank_cnt_of(input logic [2:0] code);
    logic [4:0] banks;
    unique case (code)
      3'd1:    banks = 5'd1;
      3'd2:    banks = 5'd1;
      3'd3:    banks = 5'd4;
      3'd4:    banks = 5'd16;
      default: banks = 5'd0;
    endcase
    return banks;
  endfunction

  function automatic logic [17:0] ram_bytes_of(input logic [2:0] code);
    logic [17:0] nbytes;
    unique case (code)
      3'd1:    nbytes = 18'd2048;
      3'd2:    nbytes = 18'd8192;
      3'd3:    nbytes = 18'd32768;
      3'd4:    nbytes = 18'd131072;
      default: nbytes = 18'd0;
    endcase
    return nbytes;
  endfunction

endpackage

FILE: sv/chc_front.sv
// front end: decodes each header byte by its offset into a classified item
module chc_front
  import chc_pkg::*;
(
  input  logic [6:0] offset,
  input  logic [7:0] data,
  input  logic       last,
  output item_t      item
);

  logic in_logo;

  assign in_logo = (offset < 7'(LOGO_BYTES));

  always_comb begin
    item.data      = data;
    item.logo_bad  = in_logo && (data != LOGO_TABLE[offset[5:0]]);
    item.sum_en    = (offset >= SUM_FIRST) && (offset < SUM_END) && (offset < WINDOW_LEN);
    item.type_wr   = (offset == OFS_TYPE);
    item.rom_wr    = (offset == OFS_ROM);
    item.ram_wr    = (offset == OFS_RAM);
    item.stored_wr = (offset == OFS_STORED);
    item.last      = last;
  end

endmodule

FILE: sv/chc_queue.sv
// short fifo of classified items between front and back end
module chc_queue
  import chc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/chc_back.sv
// back end: header state, checksum accumulator and result register
module chc_back
  import chc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic       logo_match_r, logo_match_nxt;
  logic [7:0] checksum_acc_r, checksum_acc_nxt;
  logic [7:0] type_code_r, type_code_nxt;
  logic [7:0] rom_code_r, rom_code_nxt;
  logic [7:0] ram_code_r, ram_code_nxt;
  logic [7:0] stored_r, stored_nxt;
  logic       res_valid_r;
  result_t    res_r, res_nxt;
  logic       take, finish, ok;

  // a last item needs the result register free
  assign item_ready = !item.last || !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;
  assign finish     = take && item.last;

  always_comb begin
    logo_match_nxt   = logo_match_r && !item.logo_bad;
    checksum_acc_nxt = item.sum_en ? (checksum_acc_r - item.data - 8'd1) : checksum_acc_r;
    type_code_nxt    = item.type_wr ? item.data : type_code_r;
    rom_code_nxt     = item.rom_wr ? item.data : rom_code_r;
    ram_code_nxt     = item.ram_wr ? item.data : ram_code_r;
    stored_nxt       = item.stored_wr ? item.data : stored_r;
  end

  always_comb begin
    ok = (type_code_nxt <= MAX_TYPE) && (rom_code_nxt <= MAX_ROM) &&
         (ram_code_nxt <= MAX_RAM) && logo_match_nxt && (checksum_acc_nxt == stored_nxt);
    res_nxt = '0;
    if (ok) begin
      res_nxt.ok           = 1'b1;
      res_nxt.mapper       = MAPPER_TABLE[type_code_nxt[4:0]];
      res_nxt.rom_bank_cnt = 8'(9'd2 << rom_code_nxt[2:0]);
      res_nxt.ram_bank_cnt = ram_bank_cnt_of(ram_code_nxt[2:0]);
      res_nxt.ram_bytes    = ram_bytes_of(ram_code_nxt[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logo_match_r   <= 1'b1;
      checksum_acc_r <= '0;
      type_code_r    <= '0;
      rom_code_r     <= '0;
      ram_code_r     <= '0;
      stored_r       <= '0;
    end else if (finish) begin
      // state returns to its reset value after each result
      logo_match_r   <= 1'b1;
      checksum_acc_r <= '0;
      type_code_r    <= '0;
      rom_code_r     <= '0;
      ram_code_r     <= '0;
      stored_r       <= '0;
    end else if (take) begin
      logo_match_r   <= logo_match_nxt;
      checksum_acc_r <= checksum_acc_nxt;
      type_code_r    <= type_code_nxt;
      rom_code_r     <= rom_code_nxt;
      ram_code_r     <= ram_code_nxt;
      stored_r       <= stored_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (finish) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: sv/cartridge_header_checker.sv
// Cartridge header checker: takes the 76-byte header window (offset 0 is ROM
// address 0x104) as a stream of one byte per transfer, checks the logo bytes,
// the header checksum and the type, ROM and RAM size codes, and gives one
// result transfer per byte marked with in_tlast. A byte is taken every cycle
// while the front queue has room; the back end retires one queued byte per
// cycle unless a last byte waits on a stalled result, so the sustained rate
// is one byte per clock while the output is not stalled. out_tvalid is driven
// by a result register set as the last byte leaves the queue; while that
// register is stalled, bytes of the next header keep flowing in and only the
// next last byte waits, so in_tready falls only once QUEUE_DEPTH bytes pile up.
module cartridge_header_checker
  import chc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // offset[6:0], data[14:7], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // header_ok, mapper_kind, rom_bank_count,
                                  // ram_bank_count, ram_bytes, zero pad
);

  item_t   fr_item;
  item_t   bk_item;
  logic    bk_valid, bk_ready;
  result_t res;

  chc_front u_front (
    .offset (in_tdata[6:0]),
    .data   (in_tdata[14:7]),
    .last   (in_tlast),
    .item   (fr_item)
  );

  chc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_item   (bk_item)
  );

  chc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (bk_valid),
    .item_ready (bk_ready),
    .item       (bk_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {4'b0000, res.ram_bytes, res.ram_bank_cnt, res.rom_bank_cnt,
                      res.mapper, res.ok};

endmodule

FILE: sv/chc_checker.sv
// port-level checks for the cartridge header checker, bound to the top level
module chc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a failed header reports all fields as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[39:1] == 39'd0)
    else $error("failed header with nonzero fields");

  // a passing header has a power-of-two rom bank count of at least two
  a_rom_banks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> $onehot(out_tdata[12:5]) && !out_tdata[5])
    else $error("bad rom bank count");

  // mapper kind is never 6 or 7 (the table gives -1..5), and the top pad stays zero
  a_mapper: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:1] != 4'd6 && out_tdata[4:1] != 4'd7 &&
                   out_tdata[39:36] == 4'd0)
    else $error("mapper kind out of range");

  // no result straight out of reset
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result right after reset");

endmodule

bind cartridge_header_checker chc_checker u_chc_checker (.*);
